// ===== hdl/hmb_pkg.sv =====
// shared constants, types and helpers for the mutex bank
`default_nettype none

package hmb_pkg;

   localparam int SLOTS        = 16;
   localparam int SLOT_W       = $clog2(SLOTS);
   localparam int SLOT_FIELD_W = 4;
   localparam int TASK_W       = 8;
   localparam int HANDLE_W     = 4;

   typedef enum logic [1:0] {
      OP_CREATE  = 2'd0,
      OP_ENTER   = 2'd1,
      OP_EXIT    = 2'd2,
      OP_DESTROY = 2'd3
   } op_type;

   typedef enum logic [2:0] {
      ST_DONE    = 3'd0,
      ST_WAIT    = 3'd1,
      ST_INVALID = 3'd2,
      ST_BUSY    = 3'd3,
      ST_FULL    = 3'd4,
      ST_KILL    = 3'd5
   } status_type;

   typedef enum logic {
      MT_NORMAL = 1'b0,
      MT_STRICT = 1'b1
   } mutex_type_type;

   typedef logic [SLOT_W-1:0] slot_idx_type;

   typedef struct packed {
      logic              strict;
      logic [TASK_W-1:0] holder;
   } entry_type;

   typedef struct packed {
      logic         set;
      logic         clr;
      slot_idx_type idx;
   } flag_cmd_type;

   typedef struct packed {
      logic         free_found;
      slot_idx_type free_idx;
      logic         hit;
   } flag_stat_type;

   function automatic slot_idx_type slot_index(input logic [SLOT_FIELD_W-1:0] s);
      return SLOT_W'(s);
   endfunction

   function automatic logic slot_in_range(input logic [SLOT_FIELD_W-1:0] s);
      return 32'(s) < 32'(SLOTS);
   endfunction

endpackage

`default_nettype wire

// ===== hdl/hmb_if.sv =====
// request and response channel interfaces
`default_nettype none

interface hmb_req_if;
   logic                                 valid;
   logic                                 ready;
   hmb_pkg::op_type                      op;
   logic [hmb_pkg::SLOT_FIELD_W-1:0]     slot;
   hmb_pkg::mutex_type_type              mutex_type;
   logic [hmb_pkg::TASK_W-1:0]           task_id;

   modport source (output valid, op, slot, mutex_type, task_id, input ready);
   modport sink   (input valid, op, slot, mutex_type, task_id, output ready);
endinterface

interface hmb_rsp_if;
   logic                             valid;
   logic                             ready;
   hmb_pkg::status_type              status;
   logic [hmb_pkg::HANDLE_W-1:0]     handle;
   logic                             notify;

   modport source (output valid, status, handle, notify, input ready);
   modport sink   (input valid, status, handle, notify, output ready);
endinterface

`default_nettype wire

// ===== hdl/hmb_ram.sv =====
// simple dual port ram, registered read, write-first on address match
`default_nettype none

module hmb_ram #(
   parameter int WIDTH  = 9,
   parameter int DEPTH  = 16,
   parameter int ADDR_W = $clog2(DEPTH)
) (
   input  wire logic              clock,
   input  wire logic              wr_en,
   input  wire logic [ADDR_W-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]  wr_data,
   input  wire logic              rd_en,
   input  wire logic [ADDR_W-1:0] rd_addr,
   output      logic [WIDTH-1:0]  rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         if (wr_en && (wr_addr == rd_addr)) begin
            rd_data_ff <= wr_data;
         end else begin
            rd_data_ff <= mem_ff[rd_addr];
         end
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

// ===== hdl/hmb_flags.sv =====
// slot in-use flags with lowest free slot search
`default_nettype none

module hmb_flags (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire hmb_pkg::flag_cmd_type cmd,
   input  wire hmb_pkg::slot_idx_type query_idx,
   output      hmb_pkg::flag_stat_type stat
);

   logic [hmb_pkg::SLOTS-1:0] in_use_ff;
   logic [hmb_pkg::SLOTS-1:0] in_use_in;

   always_comb begin
      in_use_in = in_use_ff;
      if (cmd.set) begin
         in_use_in[cmd.idx] = 1'b1;
      end
      if (cmd.clr) begin
         in_use_in[cmd.idx] = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_use_ff <= '0;
      end else begin
         in_use_ff <= in_use_in;
      end
   end

   always_comb begin
      stat.free_found = 1'b0;
      stat.free_idx   = '0;
      for (int i = hmb_pkg::SLOTS - 1; i >= 0; i--) begin
         if (!in_use_ff[i]) begin
            stat.free_found = 1'b1;
            stat.free_idx   = hmb_pkg::SLOT_W'(i);
         end
      end
      stat.hit = in_use_ff[query_idx];
   end

   chk_set_clr_exclusive: assert property (@(posedge clock) disable iff (reset)
      !(cmd.set && cmd.clr))
      else $error("flag set and clear in the same cycle");

   chk_set_was_free: assert property (@(posedge clock) disable iff (reset)
      cmd.set |-> !in_use_ff[cmd.idx])
      else $error("slot allocated while already in use");

   chk_set_lands: assert property (@(posedge clock) disable iff (reset)
      cmd.set |=> in_use_ff[$past(cmd.idx)])
      else $error("allocated slot not marked in use");

endmodule

`default_nettype wire

// ===== hdl/hardware_mutex_bank.sv =====
// top level of the mutex bank: request pipeline, slot table and response register
//
//  channel   dir  handshake     payload
//  req_ch    in   valid/ready   op, slot, mutex_type, task_id
//  rsp_ch    out  valid/ready   status, handle, notify
//
// one item per cycle unless rsp_ch stalls; rsp_ch.valid is from the response register
// type and holder sit in a registered ram read at accept, written back on advance;
// a write-first bypass in the ram covers back to back items on the same slot
// in-use flags are flip-flops cleared by reset; no clearing pass
// a stalled response holds the pipeline stage, which then holds req_ch.ready low
`default_nettype none

module hardware_mutex_bank (
   input wire logic   clock,
   input wire logic   reset,
   hmb_req_if.sink    req_ch,
   hmb_rsp_if.source  rsp_ch
);

   logic                            s1_valid_ff;
   hmb_pkg::op_type                 s1_op_ff;
   hmb_pkg::slot_idx_type           s1_idx_ff;
   logic                            s1_range_ff;
   hmb_pkg::mutex_type_type         s1_typ_ff;
   logic [hmb_pkg::TASK_W-1:0]      s1_tid_ff;

   logic                            out_valid_ff;
   hmb_pkg::status_type             out_status_ff;
   logic [hmb_pkg::HANDLE_W-1:0]    out_handle_ff;
   logic                            out_notify_ff;

   hmb_pkg::status_type             status_in;
   logic [hmb_pkg::HANDLE_W-1:0]    handle_in;
   logic                            notify_in;

   logic                            req_acc;
   logic                            s1_adv;
   logic                            wr_want;
   hmb_pkg::slot_idx_type           wr_addr;
   hmb_pkg::entry_type              wr_entry;
   hmb_pkg::entry_type              rd_entry;
   logic [$bits(hmb_pkg::entry_type)-1:0] rd_raw;
   hmb_pkg::flag_cmd_type           flag_cmd;
   hmb_pkg::flag_stat_type          flag_stat;
   logic                            flag_set;
   logic                            flag_clr;

   assign s1_adv       = s1_valid_ff && (!out_valid_ff || rsp_ch.ready);
   assign req_ch.ready = !s1_valid_ff || s1_adv;
   assign req_acc      = req_ch.valid && req_ch.ready;

   hmb_ram #(
      .WIDTH ($bits(hmb_pkg::entry_type)),
      .DEPTH (hmb_pkg::SLOTS)
   ) u_table (
      .clock   (clock),
      .wr_en   (wr_want && s1_adv),
      .wr_addr (wr_addr),
      .wr_data (wr_entry),
      .rd_en   (req_acc),
      .rd_addr (hmb_pkg::slot_index(req_ch.slot)),
      .rd_data (rd_raw)
   );

   assign rd_entry = hmb_pkg::entry_type'(rd_raw);

   hmb_flags u_flags (
      .clock     (clock),
      .reset     (reset),
      .cmd       (flag_cmd),
      .query_idx (s1_idx_ff),
      .stat      (flag_stat)
   );

   always_comb begin
      status_in = hmb_pkg::ST_DONE;
      handle_in = '0;
      notify_in = 1'b0;
      wr_want   = 1'b0;
      wr_addr   = s1_idx_ff;
      wr_entry  = rd_entry;
      flag_set  = 1'b0;
      flag_clr  = 1'b0;
      if (s1_op_ff == hmb_pkg::OP_CREATE) begin
         if (flag_stat.free_found) begin
            flag_set        = 1'b1;
            wr_want         = 1'b1;
            wr_addr         = flag_stat.free_idx;
            wr_entry.strict = s1_typ_ff;
            wr_entry.holder = '0;
            handle_in       = hmb_pkg::HANDLE_W'(flag_stat.free_idx);
         end else begin
            status_in = hmb_pkg::ST_FULL;
         end
      end else if (!(s1_range_ff && flag_stat.hit)) begin
         status_in = hmb_pkg::ST_INVALID;
      end else begin
         unique case (s1_op_ff)
            hmb_pkg::OP_ENTER: begin
               if (rd_entry.holder == '0) begin
                  wr_want         = 1'b1;
                  wr_entry.holder = rd_entry.strict ? s1_tid_ff
                                                    : hmb_pkg::TASK_W'(1);
               end else if (!(rd_entry.strict && rd_entry.holder == s1_tid_ff)) begin
                  status_in = hmb_pkg::ST_WAIT;
               end
            end
            hmb_pkg::OP_EXIT: begin
               if (rd_entry.strict && rd_entry.holder != s1_tid_ff) begin
                  status_in = hmb_pkg::ST_KILL;
               end else begin
                  wr_want         = 1'b1;
                  wr_entry.holder = '0;
                  notify_in       = 1'b1;
               end
            end
            hmb_pkg::OP_DESTROY: begin
               if (rd_entry.holder != '0) begin
                  status_in = hmb_pkg::ST_BUSY;
               end else begin
                  flag_clr = 1'b1;
               end
            end
            default: begin
               status_in = hmb_pkg::ST_INVALID;
            end
         endcase
      end
   end

   always_comb begin
      flag_cmd.set = flag_set && s1_adv;
      flag_cmd.clr = flag_clr && s1_adv;
      flag_cmd.idx = wr_addr;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (req_acc) begin
         s1_valid_ff <= 1'b1;
      end else if (s1_adv) begin
         s1_valid_ff <= 1'b0;
      end
      if (req_acc) begin
         s1_op_ff    <= req_ch.op;
         s1_idx_ff   <= hmb_pkg::slot_index(req_ch.slot);
         s1_range_ff <= hmb_pkg::slot_in_range(req_ch.slot);
         s1_typ_ff   <= req_ch.mutex_type;
         s1_tid_ff   <= req_ch.task_id;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (s1_adv) begin
         out_valid_ff <= 1'b1;
      end else if (rsp_ch.ready) begin
         out_valid_ff <= 1'b0;
      end
      if (s1_adv) begin
         out_status_ff <= status_in;
         out_handle_ff <= handle_in;
         out_notify_ff <= notify_in;
      end
   end

   assign rsp_ch.valid  = out_valid_ff;
   assign rsp_ch.status = out_status_ff;
   assign rsp_ch.handle = out_handle_ff;
   assign rsp_ch.notify = out_notify_ff;

   chk_accept_room: assert property (@(posedge clock) disable iff (reset)
      req_acc |-> (!s1_valid_ff || s1_adv))
      else $error("item accepted while pipeline stage is blocked");

   chk_adv_fills_out: assert property (@(posedge clock) disable iff (reset)
      s1_adv |=> out_valid_ff)
      else $error("advanced item did not reach the response register");

   chk_notify_done: assert property (@(posedge clock) disable iff (reset)
      out_valid_ff && out_notify_ff |-> out_status_ff == hmb_pkg::ST_DONE)
      else $error("notify raised on a failed item");

   chk_handle_done: assert property (@(posedge clock) disable iff (reset)
      out_valid_ff && out_handle_ff != '0 |-> out_status_ff == hmb_pkg::ST_DONE)
      else $error("handle returned on a failed item");

endmodule

`default_nettype wire
